// ===== rtl/core/ptc_pkg.sv =====
// ptc_pkg: shared types and constants for the persistent threshold-crossing block.
// Used by ptc_cell, ptc_out_queue and persistent_threshold_crossing; depends on nothing.

package ptc_pkg;

    // Configuration register indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_PERSIST   = 1'b1;

    // Reset values of the configuration registers
    localparam logic signed [15:0] THRESHOLD_RESET = 16'sd0;
    localparam logic [7:0]         PERSIST_RESET   = 8'd2;

    // Output queue geometry
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Per-sample control broadcast to every cell of the chain
    typedef struct packed {
        logic advance;   // a sample word is taken this cycle
        logic clear;     // that word ends the trace
        logic ge;        // sample at or above threshold
        logic le;        // sample at or below threshold
    } cell_ctrl_t;

    // Run flags held by one cell: the last k samples all sit on that side
    typedef struct packed {
        logic above;
        logic below;
    } cell_link_t;

    // One result word
    typedef struct packed {
        logic [15:0] cross_index;
        logic        rising;
        logic        last_of_run;
    } result_t;

endpackage

// ===== rtl/core/ptc_cell.sv =====
// ptc_cell: one cell of the run chain, holding "run >= k" flags for both sides.
// Depends on ptc_pkg for the control and link structs.

module ptc_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ptc_pkg::cell_ctrl_t ctrl,
    input  ptc_pkg::cell_link_t prev,
    output ptc_pkg::cell_link_t state,
    output ptc_pkg::cell_link_t upd
);

    ptc_pkg::cell_link_t state_reg;
    ptc_pkg::cell_link_t state_next;

    // A run of k needs this sample on the side and a run of k-1 before it
    assign upd.above = ctrl.ge & prev.above;
    assign upd.below = ctrl.le & prev.below;

    always_comb
    begin
        state_next = state_reg;
        if (ctrl.advance)
        begin
            if (ctrl.clear)
                state_next = '0;
            else
                state_next = upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

// ===== rtl/core/ptc_out_queue.sv =====
// ptc_out_queue: small result queue taking up to two words a cycle, giving one.
// Depends on ptc_pkg for the result type and queue geometry.

module ptc_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push0_valid,
    input  ptc_pkg::result_t push0,
    input  logic             push1_valid,
    input  ptc_pkg::result_t push1,
    output logic             has_room,
    output logic             head_valid,
    output ptc_pkg::result_t head,
    input  logic             head_ready
);

    ptc_pkg::result_t              mem_reg [ptc_pkg::QDEPTH];
    logic [ptc_pkg::QPW-1:0]       rd_ptr_reg;
    logic [ptc_pkg::QPW-1:0]       rd_ptr_next;
    logic [ptc_pkg::QPW-1:0]       wr_ptr_reg;
    logic [ptc_pkg::QPW-1:0]       wr_ptr_next;
    logic [ptc_pkg::QCW-1:0]       count_reg;
    logic [ptc_pkg::QCW-1:0]       count_next;
    logic [ptc_pkg::QPW-1:0]       wr_ptr_b;
    logic                          pop;
    logic [1:0]                    n_push;

    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign pop        = head_valid & head_ready;
    // Room for a full pair of result words
    assign has_room   = (count_reg <= ptc_pkg::QCW'(ptc_pkg::QDEPTH - 2));

    assign n_push   = {1'b0, push0_valid} + {1'b0, push1_valid};
    assign wr_ptr_b = wr_ptr_reg + 1'b1;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + ptc_pkg::QPW'(pop);
        wr_ptr_next = wr_ptr_reg + ptc_pkg::QPW'(n_push);
        count_next  = count_reg + ptc_pkg::QCW'(n_push) - ptc_pkg::QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0_valid)
            mem_reg[wr_ptr_reg] <= push0;
        if (push1_valid)
            mem_reg[wr_ptr_b] <= push1;
    end

endmodule

// ===== rtl/core/persistent_threshold_crossing.sv =====
// persistent_threshold_crossing: top level of the persistent threshold-crossing detector.
// Depends on ptc_pkg, ptc_cell and ptc_out_queue.

// Takes one signed trace sample word per cycle, unless held, and reports each index i
// whose sample lies on one side of the threshold while the next L samples
// (L = persistence_len, 0 read as 1, clamped to MAX_PERSIST) lie at or beyond it on the
// other side; a sample equal to the threshold counts for both sides. The crossing at index
// i is reported when sample i+L is taken, and on the final sample of a trace one more
// index is checked with a window of L-1 samples. Up to two result words come from one
// sample, in rising index order, the last one flagged by last_of_run. Throughput is one
// sample word per cycle when not held; a result word is queued when its sample is taken,
// and the output moves one word per cycle while out_ready is high. The input is held
// whenever three or more words wait in the four-word result queue, so that a pair from
// one sample always fits; with the output always ready this stalls the input only after
// two-word samples come close together. Indices saturate at min(MAX_SAMPLES-1, 65535).
// Configuration writes are taken in any cycle and must only be issued while the block is idle.

module persistent_threshold_crossing #(
    parameter longint unsigned MAX_SAMPLES = 64'd65536,
    parameter int              MAX_PERSIST = 255
) (
    input  logic               clk,
    input  logic               rst_n,

    // Configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,

    // Sample channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sample,
    input  logic               final_sample,

    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        cross_index,
    output logic               rising,
    output logic               last_of_run
);

    // Cell k (1..NCELL) holds "the run on a side is at least k"; link 0 is always true.
    localparam int NCELL = MAX_PERSIST + 1;
    localparam int LW    = $clog2(MAX_PERSIST + 2);
    localparam int CW    = ((LW > 16) ? LW : 16) + 1;
    localparam logic [15:0] IDX_CAP =
        (MAX_SAMPLES - 64'd1 > 64'd65535) ? 16'hFFFF : 16'(MAX_SAMPLES - 64'd1);

    // Configuration registers
    logic signed [15:0]  threshold_reg;
    logic signed [15:0]  threshold_next;
    logic [7:0]          persist_reg;
    logic [7:0]          persist_next;

    // Sample index of the word being taken
    logic [15:0]         count_reg;
    logic [15:0]         count_next;

    logic                take;
    logic [LW-1:0]       len;
    logic [LW-1:0]       len_p1;
    logic [LW-1:0]       len_m1;
    ptc_pkg::cell_ctrl_t ctrl;
    ptc_pkg::cell_link_t chain_state [NCELL+1];
    logic [NCELL:0]      above_upd;
    logic [NCELL:0]      below_upd;

    logic                win_full_ok;
    logic                win_short_ok;
    logic                rise_full;
    logic                fall_full;
    logic                rise_short;
    logic                fall_short;
    logic                emit_full;
    logic                emit_short;
    logic [15:0]         idx_full;
    logic [15:0]         idx_short;
    ptc_pkg::result_t    res_full;
    ptc_pkg::result_t    res_short;
    logic                push0_valid;
    ptc_pkg::result_t    push0;
    logic                push1_valid;
    ptc_pkg::result_t    push1;
    logic                q_room;
    ptc_pkg::result_t    q_head;

    // ---------------------------------------------------------------- configuration
    assign cfg_ready = 1'b1;

    always_comb
    begin
        threshold_next = threshold_reg;
        persist_next   = persist_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                ptc_pkg::REG_THRESHOLD: threshold_next = cfg_data;
                ptc_pkg::REG_PERSIST:   persist_next   = cfg_data[7:0];
                default:                threshold_next = threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ptc_pkg::THRESHOLD_RESET;
            persist_reg   <= ptc_pkg::PERSIST_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
            persist_reg   <= persist_next;
        end
    end

    // Effective window length: zero acts as one, clamp to the deepest cell window
    always_comb
    begin
        if (persist_reg == 8'd0)
            len = LW'(1);
        else if (32'(persist_reg) > 32'(MAX_PERSIST))
            len = LW'(MAX_PERSIST);
        else
            len = LW'(persist_reg);
    end

    assign len_p1 = len + 1'b1;
    assign len_m1 = len - 1'b1;

    // ---------------------------------------------------------------- input side
    // Take a word only while the queue can absorb a full pair of results
    assign in_ready = q_room;
    assign take     = in_valid & in_ready;

    assign ctrl.advance = take;
    assign ctrl.clear   = final_sample;
    assign ctrl.ge      = (sample >= threshold_reg);
    assign ctrl.le      = (sample <= threshold_reg);

    // ---------------------------------------------------------------- cell chain
    assign chain_state[0] = '{above: 1'b1, below: 1'b1};
    assign above_upd[0]   = 1'b1;
    assign below_upd[0]   = 1'b1;

    for (genvar k = 1; k <= NCELL; k++)
    begin : g_cell
        ptc_pkg::cell_link_t upd_k;

        ptc_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .prev  (chain_state[k-1]),
            .state (chain_state[k]),
            .upd   (upd_k)
        );

        assign above_upd[k] = upd_k.above;
        assign below_upd[k] = upd_k.below;
    end

    // ---------------------------------------------------------------- crossing checks
    // Full window: index j-L, run exactly L including this sample
    assign win_full_ok  = (CW'(count_reg) >= CW'(len));
    assign rise_full    = above_upd[len] & ~above_upd[len_p1];
    assign fall_full    = below_upd[len] & ~below_upd[len_p1];
    assign emit_full    = take & win_full_ok & (rise_full | fall_full);
    assign idx_full     = 16'(CW'(count_reg) - CW'(len));

    // Short window at the end of a trace: index j-L+1, run exactly L-1
    assign win_short_ok = (CW'(count_reg) + CW'(1) >= CW'(len));
    assign rise_short   = above_upd[len_m1] & ~above_upd[len];
    assign fall_short   = below_upd[len_m1] & ~below_upd[len];
    assign emit_short   = take & final_sample & win_short_ok & (rise_short | fall_short);
    assign idx_short    = 16'(CW'(count_reg) + CW'(1) - CW'(len));

    // Rising wins when both sides qualify for one index
    assign res_full  = '{cross_index: idx_full,  rising: rise_full,  last_of_run: ~emit_short};
    assign res_short = '{cross_index: idx_short, rising: rise_short, last_of_run: 1'b1};

    // Pack results into the first free slots in index order
    always_comb
    begin
        push0_valid = emit_full | emit_short;
        push1_valid = emit_full & emit_short;
        push0       = emit_full ? res_full : res_short;
        push1       = res_short;
    end

    // ---------------------------------------------------------------- sample index
    always_comb
    begin
        count_next = count_reg;
        if (take)
        begin
            if (final_sample)
                count_next = '0;
            else if (count_reg < IDX_CAP)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // ---------------------------------------------------------------- output side
    ptc_out_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push0_valid (push0_valid),
        .push0       (push0),
        .push1_valid (push1_valid),
        .push1       (push1),
        .has_room    (q_room),
        .head_valid  (out_valid),
        .head        (q_head),
        .head_ready  (out_ready)
    );

    assign cross_index = q_head.cross_index;
    assign rising      = q_head.rising;
    assign last_of_run = q_head.last_of_run;

endmodule

// ===== test/persistent_threshold_crossing_tb.sv =====
// persistent_threshold_crossing_tb: self-checking testbench for the persistent threshold-crossing
// detector, with directed corner traces, long windows, back-pressure and random traces.
// Depends on ptc_pkg and persistent_threshold_crossing.

module persistent_threshold_crossing_tb;

    // Block defaults the predictor mirrors: persistence clamp, run and index saturation
    localparam int MAX_PERSIST = 255;
    localparam int RUN_CAP     = MAX_PERSIST + 1;
    localparam int IDX_CAP     = 65535;

    // Idle pause after every expected word is seen, before a register write
    localparam int DRAIN_PAUSE = 6;

    // Worst legal quiet stretch: the output hold-off, the longest receiver halt, the longest
    // sender gap and the drain pause. Take it well over ten times.
    localparam int STALL_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 250;

    typedef enum int {DRAIN_FULL, DRAIN_COIN, DRAIN_MOSTLY, DRAIN_HALT} drain_mode_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic               cfg_index    = ptc_pkg::REG_THRESHOLD;
    logic [15:0]        cfg_data     = 16'd0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic signed [15:0] sample       = 16'sd0;
    logic               final_sample = 1'b0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [15:0]        cross_index;
    logic               rising;
    logic               last_of_run;

    // Predictor copy of the registers and the trace state
    logic signed [15:0] thr_q   = ptc_pkg::THRESHOLD_RESET;
    logic [7:0]         plen_q  = ptc_pkg::PERSIST_RESET;
    logic [8:0]         run_hi  = 9'd0;
    logic [8:0]         run_lo  = 9'd0;
    logic [15:0]        idx_next = 16'd0;

    // Crossing words predicted but not yet seen on the output
    ptc_pkg::result_t crossings_due[$];

    int  mismatches    = 0;
    int  samples_sent  = 0;
    int  words_checked = 0;
    int  settings_done = 0;
    int  burst_left    = 0;
    int  idle_run      = 0;
    bit  no_gaps       = 1'b0;
    bit  holdoff_req   = 1'b0;

    persistent_threshold_crossing uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .final_sample (final_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cross_index  (cross_index),
        .rising       (rising),
        .last_of_run  (last_of_run)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // A window of 'need' samples holds if one run is exactly that long; rising wins a tie
    function automatic bit window_holds(input int need, output logic up);
        window_holds = 1'b1;
        up = 1'b0;
        if (run_hi == need)
            up = 1'b1;
        else if (run_lo != need)
            window_holds = 1'b0;
    endfunction

    // Advance the trace state by one sample and queue the crossing words it decides
    function automatic void predict_crossings(input logic signed [15:0] s, input logic fin);
        int               len;
        int               j;
        int               n;
        logic             up;
        ptc_pkg::result_t hit[2];
        len = (plen_q == 8'd0) ? 1 : int'(plen_q);
        if (len > MAX_PERSIST)
            len = MAX_PERSIST;
        j = int'(idx_next);
        n = 0;
        // Compare once on arrival; a sample equal to the threshold extends both runs
        if (s >= thr_q)
        begin
            if (run_hi < RUN_CAP)
                run_hi++;
        end
        else
            run_hi = 9'd0;
        if (s <= thr_q)
        begin
            if (run_lo < RUN_CAP)
                run_lo++;
        end
        else
            run_lo = 9'd0;
        // Full window: index j-len is decided now
        if (j >= len && window_holds(len, up))
        begin
            hit[n].cross_index = 16'(j - len);
            hit[n].rising      = up;
            n++;
        end
        // Final sample: one more index, its window one sample short
        if (fin && j >= len - 1 && window_holds(len - 1, up))
        begin
            hit[n].cross_index = 16'(j - len + 1);
            hit[n].rising      = up;
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            hit[i].last_of_run = (i == n - 1);
            crossings_due = {crossings_due, hit[i]};
        end
        if (fin)
        begin
            run_hi   = 9'd0;
            run_lo   = 9'd0;
            idx_next = 16'd0;
        end
        else if (j < IDX_CAP)
            idx_next = 16'(j + 1);
    endfunction

    // Offer one sample word, hold it until taken, then idle between bursts
    task automatic send_sample(input logic signed [15:0] s, input logic fin);
        int gap;
        in_valid     <= 1'b1;
        sample       <= s;
        final_sample <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_crossings(s, fin);
        samples_sent++;
        if (!no_gaps)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                // Mostly short bursts, now and then a long unbroken stretch
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(0, 12);
            end
        end
    endtask

    // Drop the input, wait for every expected word, then let the pipeline settle
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (crossings_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // Write both registers back to back, holding valid across the pair
    task automatic set_config(input logic signed [15:0] thr, input logic [7:0] plen);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_index <= ptc_pkg::REG_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        thr_q = thr;
        cfg_index <= ptc_pkg::REG_PERSIST;
        cfg_data  <= {8'd0, plen};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        plen_q = plen;
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // Pick a level on one side of the threshold (0: on it), often close to it
    function automatic logic signed [15:0] pick_level(input int side);
        int lo;
        int hi;
        int span;
        lo = -32768;
        hi = 32767;
        if (side > 0)
            lo = int'(thr_q) + 1;
        else if (side < 0)
            hi = int'(thr_q) - 1;
        if (side == 0 || lo > hi)
            return thr_q;
        span = hi - lo;
        if (span > 64 && $urandom_range(0, 1) == 1)
            span = 64;
        if (side > 0)
            return 16'(lo + int'($urandom_range(0, span)));
        return 16'(hi - int'($urandom_range(0, span)));
    endfunction

    // Reset values of the registers, field extremes and an equal sample
    task automatic test_reset_defaults();
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd7, 1'b0);
        send_sample(-16'sd9, 1'b1);
    endtask

    // Threshold extremes, zero persistence, a short trace and a mid-trace threshold change
    task automatic test_directed_corners();
        set_config(-16'sd32768, 8'd0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd5, 1'b1);
        set_config(16'sd32767, 8'd1);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd2, 1'b1);
        // Fewer samples than the window: nothing may come out
        set_config(16'sd0, 8'd5);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'sd4, 1'b0);
        send_sample(16'sd9, 1'b1);
        // Earlier samples keep the comparison made on arrival
        set_config(16'sd0, 8'd2);
        send_sample(-16'sd4, 1'b0);
        send_sample(16'sd6, 1'b0);
        set_config(16'sd10, 8'd2);
        send_sample(16'sd8, 1'b0);
        send_sample(16'sd12, 1'b0);
        send_sample(16'sd12, 1'b1);
    endtask

    // Largest persistence: a full window, then a crossing decided by the short final window
    task automatic test_long_windows();
        set_config(16'sd0, 8'd255);
        for (int i = 0; i < 259; i++)
            send_sample((i < 3) ? -16'sd20 : 16'sd20, i == 258);
        for (int i = 0; i < 255; i++)
            send_sample((i < 1) ? 16'sd20 : -16'sd20, i == 254);
    endtask

    // Hold the output off for a long stretch while a crossing on every sample piles up
    task automatic test_back_pressure();
        set_config(16'sd0, 8'd1);
        no_gaps     = 1'b1;
        holdoff_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_sample(i[0] ? 16'sd300 : -16'sd300, i == 39);
        no_gaps = 1'b0;
    endtask

    // Random settings; traces built from runs around the window length, with some noise
    task automatic test_random_traces(input int phases, input int per_phase);
        int                 sent;
        int                 seg;
        int                 side;
        int                 trace_left;
        int                 eff;
        logic signed [15:0] thr;
        logic [7:0]         plen;
        logic signed [15:0] v;
        seg        = 0;
        side       = 1;
        trace_left = 0;
        for (int p = 0; p < phases; p++)
        begin
            case ($urandom_range(0, 5))
                0:       thr = -16'sd32768;
                1:       thr = 16'sd32767;
                2:       thr = 16'sd0;
                3:       thr = 16'($urandom_range(0, 400)) - 16'sd200;
                default: thr = 16'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       plen = 8'd0;
                1:       plen = 8'd255;
                2:       plen = 8'd1;
                3:       plen = 8'($urandom_range(7, 20));
                default: plen = 8'($urandom_range(2, 6));
            endcase
            // Leave any open trace running: the new setting lands mid-trace
            set_config(thr, plen);
            eff  = (plen == 8'd0) ? 1 : int'(plen);
            sent = 0;
            while (sent < per_phase)
            begin
                if (trace_left == 0)
                    trace_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                             : $urandom_range(4, 48);
                if (seg == 0)
                begin
                    side = -side;
                    seg  = $urandom_range(1, eff + 2);
                end
                case ($urandom_range(0, 19))
                    0, 1:    v = 16'($urandom);
                    2:       v = pick_level(0);
                    default: v = pick_level(side);
                endcase
                trace_left--;
                seg--;
                send_sample(v, trace_left == 0);
                sent++;
            end
        end
    endtask

    // Check each result word against the oldest expectation, then choose the next stall
    always @(posedge clk)
    begin : drain
        ptc_pkg::result_t want;
        drain_mode_t      mode;
        int               stretch;
        int               holdoff_left;
        if (out_valid && out_ready)
        begin
            words_checked++;
            if (crossings_due.size() == 0)
                report_mismatch($sformatf("unexpected word index %0d rising %0b",
                                          cross_index, rising));
            else
            begin
                want = crossings_due.pop_front();
                if (cross_index !== want.cross_index)
                    report_mismatch($sformatf("cross_index %0d, want %0d",
                                              cross_index, want.cross_index));
                if (rising !== want.rising)
                    report_mismatch($sformatf("rising %0b, want %0b at index %0d",
                                              rising, want.rising, want.cross_index));
                if (last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, want %0b at index %0d",
                                              last_of_run, want.last_of_run,
                                              want.cross_index));
            end
        end
        if (holdoff_req)
        begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_req  = 1'b0;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (stretch <= 0)
            begin
                mode    = drain_mode_t'($urandom_range(0, 3));
                stretch = $urandom_range(1, 40);
            end
            stretch--;
            case (mode)
                DRAIN_FULL:   out_ready <= 1'b1;
                DRAIN_COIN:   out_ready <= $urandom_range(0, 1);
                DRAIN_MOSTLY: out_ready <= ($urandom_range(0, 4) != 0);
                default:      out_ready <= 1'b0;
            endcase
        end
    end

    // Watchdog: end the run if no channel moves a word for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_corners();
        test_long_windows();
        test_back_pressure();
        test_random_traces(4, 60);
        wait_until_drained();
        $display("Ran %0d samples under %0d register settings; checked %0d crossing words.",
                 samples_sent, settings_done, words_checked);
        $display("Covered threshold and window extremes, short traces, mid-trace setting "
                 , "changes and output hold-off.");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
